/* rtl/core/grc_pkg.sv */
// Shared types, constants and tables for the gamepad report conditioner.
`default_nettype none
package grc_pkg;

  localparam logic [15:0] BUTTON_UNUSED = 16'h0C00;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic signed [24:0] ANG90 = 25'sd2949120;
  localparam logic signed [16:0] ANGLE_LIMIT = 17'sd23040;
  localparam logic [15:0] RADIUS_FULL = 16'hFFFF;
  localparam logic [15:0] COMP_LIMIT = 16'd32767;

  typedef enum logic [2:0] {
    REG_TRIGGER_THRESHOLD = 3'd0,
    REG_LEFT_INNER        = 3'd1,
    REG_RIGHT_INNER       = 3'd2,
    REG_OUTER             = 3'd3
  } reg_index_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic signed [24:0] atan_entry(input logic [3:0] i);
    logic signed [24:0] v;
    case (i)
      4'd0:  v = 25'sd1474560;
      4'd1:  v = 25'sd870484;
      4'd2:  v = 25'sd459940;
      4'd3:  v = 25'sd233473;
      4'd4:  v = 25'sd117189;
      4'd5:  v = 25'sd58652;
      4'd6:  v = 25'sd29333;
      4'd7:  v = 25'sd14667;
      4'd8:  v = 25'sd7334;
      4'd9:  v = 25'sd3667;
      4'd10: v = 25'sd1833;
      4'd11: v = 25'sd917;
      4'd12: v = 25'sd458;
      4'd13: v = 25'sd229;
      4'd14: v = 25'sd115;
      default: v = 25'sd57;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/grc_divider.sv */
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
`default_nettype none
module grc_divider import grc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [40:0] num,
  input  wire logic [23:0] den,
  output logic             done,
  output logic [16:0]      quot
);

  logic [40:0] rem;
  logic [40:0] dsh;
  logic [4:0]  cnt;
  logic        busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= {1'b0, den, 16'b0};
        cnt  <= 5'd17;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem  <= rem - dsh;
          quot <= {quot[15:0], 1'b1};
        end else begin
          quot <= {quot[15:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/grc_isqrt.sv */
// Digit-by-digit integer square root of a 48-bit value, one root bit per cycle.
`default_nettype none
module grc_isqrt import grc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] n_in,
  output logic             done,
  output logic [23:0]      root
);

  logic [47:0] n;
  logic [47:0] res;
  logic [47:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [47:0] trial;

  assign trial = res + bitv;
  assign root  = res[23:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n    <= n_in;
        res  <= '0;
        bitv <= 48'h4000_0000_0000;
        cnt  <= 5'd24;
        busy <= 1'b1;
      end else if (busy) begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/grc_cordic.sv */
// Vectoring CORDIC for the stick angle, one rotation step per cycle.
`default_nettype none
module grc_cordic import grc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  output logic                    done,
  output logic signed [15:0]      angle
);

  logic signed [27:0] x, y, px, py, dx, dy;
  logic signed [24:0] acc, pacc, accr, a;
  logic [3:0]         i;
  logic               busy;

  // pre-rotate into the right half plane
  always_comb begin
    px   = 28'(x_in);
    py   = 28'(y_in);
    pacc = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        px   = 28'(y_in);
        py   = -28'(x_in);
        pacc = ANG90;
      end else begin
        px   = -28'(y_in);
        py   = 28'(x_in);
        pacc = -ANG90;
      end
    end
  end

  assign dx   = y >>> i;
  assign dy   = x >>> i;
  assign accr = acc + 25'sd128;
  assign a    = accr >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= px <<< 8;
        y    <= py <<< 8;
        acc  <= pacc;
        i    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (y > 0) begin
          x   <= x + dx;
          y   <= y - dy;
          acc <= acc + atan_entry(i);
        end else if (y < 0) begin
          x   <= x - dx;
          y   <= y + dy;
          acc <= acc - atan_entry(i);
        end
        i <= i + 4'd1;
        if (i == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (done) begin
        done <= 1'b0;
      end
    end
  end

  always_comb begin
    if (a > 25'(ANGLE_LIMIT)) angle = 16'(ANGLE_LIMIT);
    else if (a < -25'(ANGLE_LIMIT)) angle = -16'(ANGLE_LIMIT);
    else angle = a[15:0];
  end

endmodule
`default_nettype wire

/* rtl/core/gamepad_report_conditioner_core.sv */
// Top level: sequencer around shared multiplier, divider, square root and CORDIC.
// Flow: up to two 17-step trigger divides, then per stick two squares, a 24-step root,
// a 17-step radius divide beside the 16-step CORDIC and two 17-step component divides;
// triggers and sticks at rest skip the divides.
// One report is worked at a time, and S_OUT holds while the result side stalls. Input
// ready is high only while the sequencer idles.
// Reset: synchronous, active high; registers return to their defaults, the previous held
// mask clears and any pending result is dropped.
`default_nettype none
module gamepad_report_conditioner_core import grc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // s_tdata: buttons[15:0], left_trigger_raw[23:16], right_trigger_raw[31:24],
  // left_stick_x[47:32], left_stick_y[63:48], right_stick_x[79:64],
  // right_stick_y[95:80]
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,
  // m_tdata: held_mask, pressed_mask, left_trigger_level, right_trigger_level,
  // left_out_x, left_out_y, left_radius, left_angle, right_out_x, right_out_y,
  // right_radius, right_angle; 16 bits each from bit 0 up
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [191:0]      m_tdata,
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [14:0]  wr_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_TRIG, S_TRIG_W, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT_W, S_RAD,
    S_RAD_W, S_ANG_W, S_CMP_M, S_CMP_D, S_CMP_W, S_NEXT, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [7:0]  trig_thr;
  logic [14:0] left_inner, right_inner, outer_dz;

  // latched report
  logic [7:0]         trig_raw [2];
  logic signed [15:0] stick_x [2];
  logic signed [15:0] stick_y [2];
  logic [15:0]        held, pressed, prev_held;

  // per-item working registers
  logic        side;      // trigger or stick being worked on
  logic        comp_y;    // component in progress: x or y
  logic [31:0] prod, r2;
  logic [15:0] mul_a, mul_b;
  logic [23:0] r8;
  logic [15:0] rad;
  logic [15:0] trig_lvl [2];
  logic [15:0] out_x [2], out_y [2], out_r [2], out_a [2];

  // shared units
  logic        div_start, div_done;
  logic [40:0] div_num;
  logic [23:0] div_den;
  logic [16:0] div_q;
  logic        sq_start, sq_done;
  logic [23:0] sq_root;
  logic        cor_start, cor_done;
  logic signed [15:0] cor_angle;
  logic        cor_seen;  // CORDIC finished while the radius divide still ran

  logic signed [15:0] cur_x, cur_y, cur_c;
  logic [14:0] cur_inner;
  logic [23:0] in8, out8;
  logic [15:0] q16, cmp_val;

  assign cur_x     = stick_x[side];
  assign cur_y     = stick_y[side];
  assign cur_c     = comp_y ? cur_y : cur_x;
  assign cur_inner = side ? right_inner : left_inner;
  assign in8       = {1'b0, cur_inner, 8'b0};
  assign out8      = {1'b0, outer_dz, 8'b0};
  assign q16       = div_q[16] ? RADIUS_FULL : div_q[15:0];
  assign cmp_val   = cur_c[15] ? 16'(-(q16 > COMP_LIMIT ? COMP_LIMIT : q16))
                               : (q16 > COMP_LIMIT ? COMP_LIMIT : q16);

  assign s_tready = (state == S_IDLE);

  // multiplier operands follow the state; product registered each cycle
  always_comb begin
    mul_a = abs16(cur_x);
    mul_b = abs16(cur_x);
    if (state == S_SQ_Y) begin
      mul_a = abs16(cur_y);
      mul_b = abs16(cur_y);
    end else if (state == S_CMP_M) begin
      mul_a = rad;
      mul_b = abs16(cur_c);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider start and operands
  always_comb begin
    div_start = 1'b0;
    div_num   = {17'b0, trig_raw[side] - trig_thr, 16'b0};
    div_den   = {16'b0, 8'd255 - trig_thr};
    unique case (state)
      S_TRIG:  div_start = (trig_raw[side] > trig_thr);
      S_RAD:   begin
        div_start = (r8 > in8) && (r8 < out8);
        div_num   = {1'b0, r8 - in8, 16'b0};
        div_den   = out8 - in8;
      end
      S_CMP_D: begin
        div_start = 1'b1;
        div_num   = {2'b0, prod, 7'b0};
        div_den   = r8;
      end
      default: ;
    endcase
  end

  assign sq_start  = (state == S_SQ_SUM);
  assign cor_start = (state == S_RAD);

  grc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  grc_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .n_in({r2 + prod, 16'b0}),
    .done(sq_done), .root(sq_root)
  );

  grc_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .x_in(cur_x), .y_in(cur_y),
    .done(cor_done), .angle(cor_angle)
  );

  // remember the CORDIC finish; its angle holds until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      cor_seen <= 1'b0;
    end else if (cor_start) begin
      cor_seen <= 1'b0;
    end else if (cor_done) begin
      cor_seen <= 1'b1;
    end
  end

  // configuration writes; out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_thr    <= 8'd30;
      left_inner  <= 15'd7849;
      right_inner <= 15'd8689;
      outer_dz    <= 15'd32000;
    end else if (wr_en) begin
      case (wr_index)
        REG_TRIGGER_THRESHOLD: trig_thr    <= wr_data[7:0];
        REG_LEFT_INNER:        left_inner  <= wr_data;
        REG_RIGHT_INNER:       right_inner <= wr_data;
        REG_OUTER:             outer_dz    <= wr_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      prev_held <= '0;
      side      <= 1'b0;
      comp_y    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // mask unused buttons, take edges against the last report
            held        <= s_tdata[15:0] & ~BUTTON_UNUSED;
            pressed     <= s_tdata[15:0] & ~BUTTON_UNUSED & ~prev_held;
            prev_held   <= s_tdata[15:0] & ~BUTTON_UNUSED;
            trig_raw[0] <= s_tdata[23:16];
            trig_raw[1] <= s_tdata[31:24];
            stick_x[0]  <= s_tdata[47:32];
            stick_y[0]  <= s_tdata[63:48];
            stick_x[1]  <= s_tdata[79:64];
            stick_y[1]  <= s_tdata[95:80];
            side        <= 1'b0;
            state       <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (trig_raw[side] > trig_thr) begin
            state <= S_TRIG_W;
          end else begin
            trig_lvl[side] <= '0;
            side  <= ~side;
            state <= side ? S_SQ_X : S_TRIG;
          end
        end
        S_TRIG_W: begin
          if (div_done) begin
            trig_lvl[side] <= q16;
            side  <= ~side;
            state <= side ? S_SQ_X : S_TRIG;
          end
        end
        S_SQ_X: state <= S_SQ_Y;
        S_SQ_Y: begin
          r2    <= prod;
          state <= S_SQ_SUM;
        end
        S_SQ_SUM: state <= S_SQRT_W;
        S_SQRT_W: begin
          if (sq_done) begin
            r8    <= sq_root;
            state <= S_RAD;
          end
        end
        S_RAD: begin
          // inner deadzone reads zero, outer reads full scale
          if (r8 <= in8) begin
            rad   <= '0;
            state <= S_ANG_W;
          end else if (r8 >= out8) begin
            rad   <= RADIUS_FULL;
            state <= S_ANG_W;
          end else begin
            state <= S_RAD_W;
          end
        end
        S_RAD_W: begin
          if (div_done) begin
            rad   <= q16;
            state <= S_ANG_W;
          end
        end
        S_ANG_W: begin
          if (cor_done || cor_seen) begin
            out_a[side] <= cor_angle;
            out_r[side] <= rad;
            comp_y      <= 1'b0;
            state       <= S_CMP_M;
          end
        end
        S_CMP_M: begin
          if (r8 == '0 || rad == '0) begin
            if (comp_y) begin
              out_y[side] <= '0;
              state <= S_NEXT;
            end else begin
              out_x[side] <= '0;
              comp_y <= 1'b1;
            end
          end else begin
            state <= S_CMP_D;
          end
        end
        S_CMP_D: state <= S_CMP_W;
        S_CMP_W: begin
          if (div_done) begin
            if (comp_y) begin
              out_y[side] <= cmp_val;
              state <= S_NEXT;
            end else begin
              out_x[side] <= cmp_val;
              comp_y <= 1'b1;
              state  <= S_CMP_M;
            end
          end
        end
        S_NEXT: begin
          side  <= ~side;
          state <= side ? S_OUT : S_SQ_X;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {out_a[1], out_r[1], out_y[1], out_x[1],
                         out_a[0], out_r[0], out_y[0], out_x[0],
                         trig_lvl[1], trig_lvl[0], pressed, held};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a report is never accepted while one is still in work
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  a_pressed_subset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:16] & ~m_tdata[15:0]) == 16'h0)
    else $error("pressed bit not held");

  a_unused_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] & BUTTON_UNUSED) == 16'h0)
    else $error("unused button bits set");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[127:112]) <= 16'sd23040)
              && ($signed(m_tdata[127:112]) >= -16'sd23040))
    else $error("left angle out of range");

endmodule
`default_nettype wire
